/* sv/rnl_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the route and neighbor lookup block.
// No dependencies; every other file imports this package.
package rnl_pkg;

    // Default table sizes.
    localparam int ROUTE_ENTRIES_DEF    = 128;
    localparam int NEIGHBOR_ENTRIES_DEF = 128;

    // Field widths fixed by the request and result formats.
    localparam int OP_W      = 2;
    localparam int SLOT_W    = 7;
    localparam int IP_W      = 32;
    localparam int PORT_W    = 8;
    localparam int MAC_W     = 48;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 1;

    // Width that holds any count register value and any table size.
    localparam int CMP_W = 13;

    // Request operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_WR_ROUTE    = 2'd0,
        OP_WR_NEIGHBOR = 2'd1,
        OP_LOOKUP      = 2'd2,
        OP_NOP         = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROUTE_COUNT    = 1'd0,
        CFG_NEIGHBOR_COUNT = 1'd1
    } cfg_idx_t;

    // Configuration handed from the top level to the lookup engine.
    typedef struct packed {
        logic [COUNT_W-1:0] route_count;
        logic [COUNT_W-1:0] neighbor_count;
    } cfg_t;

    // One lookup result.
    typedef struct packed {
        logic              route_found;
        logic [PORT_W-1:0] out_port;
        logic [IP_W-1:0]   hop_addr;
        logic              neighbor_found;
        logic [MAC_W-1:0]  hop_mac;
    } result_t;

    // Route table word.
    typedef struct packed {
        logic [IP_W-1:0]   prefix;
        logic [IP_W-1:0]   mask;
        logic [IP_W-1:0]   hop;
        logic [PORT_W-1:0] port;
    } route_entry_t;

    // Neighbor table word.
    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } nbr_entry_t;

endpackage

/* sv/rnl_if.sv */
`timescale 1ns / 1ps
// Request and result channel interfaces with valid/ready handshake.
// Depends on rnl_pkg for the field widths.
interface rnl_req_if
    import rnl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] entry_index;
    logic [IP_W-1:0]   route_prefix_in;
    logic [IP_W-1:0]   route_mask_in;
    logic [IP_W-1:0]   route_hop_in;
    logic [PORT_W-1:0] route_port_in;
    logic [IP_W-1:0]   ip_addr;
    logic [MAC_W-1:0]  mac_addr;

    modport source (
        output valid, op, entry_index, route_prefix_in, route_mask_in,
               route_hop_in, route_port_in, ip_addr, mac_addr,
        input  ready
    );
    modport sink (
        input  valid, op, entry_index, route_prefix_in, route_mask_in,
               route_hop_in, route_port_in, ip_addr, mac_addr,
        output ready
    );
endinterface

interface rnl_res_if
    import rnl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              route_found;
    logic [PORT_W-1:0] out_port;
    logic [IP_W-1:0]   hop_addr;
    logic              neighbor_found;
    logic [MAC_W-1:0]  hop_mac;

    modport source (
        output valid, route_found, out_port, hop_addr, neighbor_found, hop_mac,
        input  ready
    );
    modport sink (
        input  valid, route_found, out_port, hop_addr, neighbor_found, hop_mac,
        output ready
    );
endinterface

/* sv/rnl_engine.sv */
`timescale 1ns / 1ps
// Table memories and the scan sequencer for route and neighbor lookups.
// Depends on rnl_pkg and the rnl_req_if interface.
module rnl_engine
    import rnl_pkg::*;
#(
    parameter int ROUTE_ENTRIES    = ROUTE_ENTRIES_DEF,
    parameter int NEIGHBOR_ENTRIES = NEIGHBOR_ENTRIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    rnl_req_if.sink    req,
    output result_t    result,
    output logic       result_valid,
    input  logic       result_take
);

    // Address and counter widths.
    localparam int RAW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int NAW = (NEIGHBOR_ENTRIES > 1) ? $clog2(NEIGHBOR_ENTRIES) : 1;
    localparam int RCW = $clog2(ROUTE_ENTRIES + 1);
    localparam int NCW = $clog2(NEIGHBOR_ENTRIES + 1);
    localparam int CW  = (RCW > NCW) ? RCW : NCW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUTE,
        ST_NEIGHBOR,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [IP_W-1:0]   dst_reg, dst_next;
    result_t           res_reg, res_next;

    route_entry_t      route_mem [ROUTE_ENTRIES];
    nbr_entry_t        nbr_mem [NEIGHBOR_ENTRIES];
    route_entry_t      r_rd_reg;
    nbr_entry_t        n_rd_reg;

    logic              req_fire;
    logic              r_slot_ok;
    logic              n_slot_ok;
    logic [CW-1:0]     r_lim;
    logic [CW-1:0]     n_lim;
    logic              r_hit;
    logic              n_hit;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    // Slot range checks for table writes.
    assign r_slot_ok = CMP_W'(req.entry_index) < CMP_W'(ROUTE_ENTRIES);
    assign n_slot_ok = CMP_W'(req.entry_index) < CMP_W'(NEIGHBOR_ENTRIES);

    // Scan lengths, clipped to the table sizes.
    assign r_lim = (CMP_W'(cfg.route_count) > CMP_W'(ROUTE_ENTRIES))
                 ? CW'(ROUTE_ENTRIES) : CW'(cfg.route_count);
    assign n_lim = (CMP_W'(cfg.neighbor_count) > CMP_W'(NEIGHBOR_ENTRIES))
                 ? CW'(NEIGHBOR_ENTRIES) : CW'(cfg.neighbor_count);

    // Compare the entry read in the previous cycle.
    assign r_hit = (r_rd_reg.prefix == (dst_reg & r_rd_reg.mask));
    assign n_hit = (n_rd_reg.ip == res_reg.hop_addr);

    // Route memory: written by route requests, read at the scan counter.
    always_ff @(posedge clk)
    begin
        if (req_fire && (req.op == OP_WR_ROUTE) && r_slot_ok)
        begin
            route_mem[RAW'(req.entry_index)] <= '{prefix: req.route_prefix_in,
                                                 mask:   req.route_mask_in,
                                                 hop:    req.route_hop_in,
                                                 port:   req.route_port_in};
        end
        r_rd_reg <= route_mem[cnt_reg[RAW-1:0]];
    end

    // Neighbor memory: written by neighbor requests, read at the scan counter.
    always_ff @(posedge clk)
    begin
        if (req_fire && (req.op == OP_WR_NEIGHBOR) && n_slot_ok)
        begin
            nbr_mem[NAW'(req.entry_index)] <= '{ip: req.ip_addr, mac: req.mac_addr};
        end
        n_rd_reg <= nbr_mem[cnt_reg[NAW-1:0]];
    end

    // Scan sequencer: one read issued and one entry compared per cycle.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        dst_next   = dst_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.op == OP_LOOKUP))
                begin
                    state_next = ST_ROUTE;
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                    dst_next   = req.ip_addr;
                    res_next   = '0;
                end
            end
            ST_ROUTE:
            begin
                pend_next = (cnt_reg < r_lim);
                if (cnt_reg < r_lim)
                begin
                    cnt_next = CW'(cnt_reg + 1'b1);
                end
                if (pend_reg && r_hit)
                begin
                    res_next.route_found = 1'b1;
                    res_next.out_port    = r_rd_reg.port;
                    res_next.hop_addr    = r_rd_reg.hop;
                    state_next           = ST_NEIGHBOR;
                    cnt_next             = '0;
                    pend_next            = 1'b0;
                end
                else if (!pend_reg && (cnt_reg == r_lim))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_NEIGHBOR:
            begin
                pend_next = (cnt_reg < n_lim);
                if (cnt_reg < n_lim)
                begin
                    cnt_next = CW'(cnt_reg + 1'b1);
                end
                if (pend_reg && n_hit)
                begin
                    res_next.neighbor_found = 1'b1;
                    res_next.hop_mac        = n_rd_reg.mac;
                    state_next              = ST_DONE;
                    pend_next               = 1'b0;
                end
                else if (!pend_reg && (cnt_reg == n_lim))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (result_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg <= dst_next;
        res_reg <= res_next;
    end

    assign result       = res_reg;
    assign result_valid = (state_reg == ST_DONE);

endmodule

/* sv/route_and_neighbor_lookup.sv */
`timescale 1ns / 1ps
// Top level of the IPv4 route and neighbor lookup block.
// Depends on rnl_pkg, rnl_if.sv and rnl_engine.
//
// Usage: requests arrive on req, results leave on resp; both use valid/ready.
// A route write (op 0) or neighbor write (op 1) stores one slot in the cycle
// it is accepted and gives no result; op 3 is accepted and ignored. A lookup
// (op 2) scans the route table from slot 0, takes the first entry whose
// masked destination equals its prefix, then, if one was found, scans the
// neighbor table for the next hop, and gives exactly one result.
// Tables: both tables live in synchronous memories with a registered read and
// are read one entry per cycle while a lookup scans them; each scan covers
// the matching count register's number of entries, clipped to its table size.
// req.ready is low from a lookup's acceptance until its result moves into
// the output register; a write leaves req.ready high.
// The output register lets the engine finish the next lookup while a result
// waits; if resp.ready stays low, the engine holds its finished result and
// stops accepting requests.
// Reset clears both count registers and the control state; table contents
// are undefined until written. Configuration writes on cfg_we, cfg_index and
// cfg_data must come only while no lookup is in progress; no check enforces it.
module route_and_neighbor_lookup
    import rnl_pkg::*;
#(
    parameter int ROUTE_ENTRIES    = ROUTE_ENTRIES_DEF,
    parameter int NEIGHBOR_ENTRIES = NEIGHBOR_ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]   cfg_data,
    rnl_req_if.sink              req,
    rnl_res_if.source            resp
);

    cfg_t    cfg_reg, cfg_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;
    result_t eng_result;
    logic    eng_valid;
    logic    out_load;

    // Configuration register decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROUTE_COUNT:    cfg_next.route_count    = cfg_data;
                CFG_NEIGHBOR_COUNT: cfg_next.neighbor_count = cfg_data;
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    rnl_engine #(
        .ROUTE_ENTRIES    (ROUTE_ENTRIES),
        .NEIGHBOR_ENTRIES (NEIGHBOR_ENTRIES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .req          (req),
        .result       (eng_result),
        .result_valid (eng_valid),
        .result_take  (out_load)
    );

    // Output register: load when empty or being drained this cycle.
    assign out_load       = eng_valid && (!out_valid_reg || resp.ready);
    assign out_valid_next = out_load ? 1'b1 : (resp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= eng_result;
        end
    end

    assign resp.valid          = out_valid_reg;
    assign resp.route_found    = out_data_reg.route_found;
    assign resp.out_port       = out_data_reg.out_port;
    assign resp.hop_addr       = out_data_reg.hop_addr;
    assign resp.neighbor_found = out_data_reg.neighbor_found;
    assign resp.hop_mac        = out_data_reg.hop_mac;

`ifndef SYNTHESIS
    // A neighbor is only ever looked up after a route was found.
    a_nbr_needs_route: assert property (@(posedge clk) disable iff (!rst_n)
        resp.valid |-> (!resp.neighbor_found || resp.route_found))
        else $error("neighbor_found set without route_found");

    // A miss on the route table leaves every result field at zero.
    a_no_route_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (resp.valid && !resp.route_found) |->
            ((resp.out_port == '0) && (resp.hop_addr == '0) && (resp.hop_mac == '0)))
        else $error("result fields not cleared on a route miss");

    // A missing neighbor gives a zero hardware address.
    a_no_nbr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (resp.valid && !resp.neighbor_found) |-> (resp.hop_mac == '0))
        else $error("hop_mac not cleared on a neighbor miss");

    // Accepting a lookup locks out further requests until it completes.
    a_lookup_locks: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.op == OP_LOOKUP)) |=> !req.ready)
        else $error("request accepted while a lookup is in progress");
`endif

endmodule
